// ----- hw/rtl/vam_pkg.sv -----
`default_nettype none

package vam_pkg;

  localparam int unsigned AlarmRun   = 3;
  localparam int unsigned FaultRun   = 3;
  localparam int unsigned CountWidth = 16;

  localparam int unsigned RunW      = $clog2(AlarmRun + 1);
  localparam int unsigned AxisW     = 15;
  localparam int unsigned DiffW     = 16;
  localparam int unsigned LimitW    = 14;
  localparam int unsigned MagW      = 16;
  localparam int unsigned FcntW     = 16;
  localparam int unsigned SqW       = 30;
  localparam int unsigned SumW      = 32;
  localparam int unsigned RemW      = 19;
  localparam int unsigned RootSteps = SumW / 2;
  localparam int unsigned StepW     = $clog2(RootSteps);

  localparam logic [LimitW-1:0] LimitReset = LimitW'(1000);

  typedef struct packed {
    logic                    read_ok;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dz;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkSquare,
    BkRoot,
    BkCommit
  } bk_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/vibration_alarm_monitor.sv -----
`default_nettype none

// channel  direction  handshake                fields
// in       input      in_valid_i / in_stall_o  read_ok, accel_x/y/z_mg
// out      output     out_valid_o / out_stall_i vib_mag .. recovered
// cfg      input      cfg_we_i                 cfg_wdata_i (vibration_limit)
//
// A good read passes through the back end in order: dequeue, the three
// squares through one multiplier, the bit-per-cycle square root, then
// commit. A failed read goes from dequeue straight to commit. The front takes
// a beat per cycle into a 2-entry queue and stalls only when it is full.
// The output register holds a beat under stall; commit waits until it frees.
// Reset (async, active low) clears the queue, the state and the limit to 1000.

module vibration_alarm_monitor (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire        [13:0] cfg_wdata_i,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               read_ok_i,
  input  wire signed [14:0] accel_x_mg_i,
  input  wire signed [14:0] accel_y_mg_i,
  input  wire signed [14:0] accel_z_mg_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic       [15:0] vib_mag_o,
  output logic              vib_alarm_o,
  output logic              sample_valid_o,
  output logic              sensor_fault_o,
  output logic       [15:0] failure_count_o,
  output logic              recovered_o
);
  import vam_pkg::*;

  q_stat_t  q_stat;
  q_entry_t push_entry, pop_entry;
  logic     push, pop;

  vam_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .read_ok_i    (read_ok_i),
    .accel_x_mg_i (accel_x_mg_i),
    .accel_y_mg_i (accel_y_mg_i),
    .accel_z_mg_i (accel_z_mg_i),
    .q_stat_i     (q_stat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  vam_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .stat_o  (q_stat)
  );

  vam_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .q_stat_i        (q_stat),
    .entry_i         (pop_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .vib_mag_o       (vib_mag_o),
    .vib_alarm_o     (vib_alarm_o),
    .sample_valid_o  (sample_valid_o),
    .sensor_fault_o  (sensor_fault_o),
    .failure_count_o (failure_count_o),
    .recovered_o     (recovered_o)
  );

  a_queue_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue full and empty at once");

  a_push_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !q_stat.empty)
    else $error("accepted beat missing from queue");

  a_fault_not_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sensor_fault_o) |-> !sample_valid_o)
    else $error("fault and valid both set");

  a_recovered : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && recovered_o) |-> (sample_valid_o && !sensor_fault_o))
    else $error("recovery without a good sample");

endmodule

`default_nettype wire

// ----- hw/rtl/vam_queue.sv -----
`default_nettype none

module vam_queue (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  vam_pkg::q_entry_t   entry_i,
  input  wire                 pop_i,
  output vam_pkg::q_entry_t   entry_o,
  output vam_pkg::q_stat_t    stat_o
);
  import vam_pkg::*;

  q_entry_t   mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign entry_o      = mem_q[rd_q];

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vam_front.sv -----
`default_nettype none

module vam_front (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_stall_o,
  input  wire                      read_ok_i,
  input  wire signed [14:0]        accel_x_mg_i,
  input  wire signed [14:0]        accel_y_mg_i,
  input  wire signed [14:0]        accel_z_mg_i,
  input  vam_pkg::q_stat_t         q_stat_i,
  output logic                     push_o,
  output vam_pkg::q_entry_t        entry_o
);
  import vam_pkg::*;

  logic signed [AxisW-1:0] last_x_q, last_y_q, last_z_q;
  logic                    have_last_q;
  logic                    accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;
  assign push_o     = accept;

  // first good sample has no predecessor: zero difference gives a zero root
  always_comb begin
    entry_o.read_ok = read_ok_i;
    entry_o.dx      = '0;
    entry_o.dy      = '0;
    entry_o.dz      = '0;
    if (have_last_q) begin
      entry_o.dx = DiffW'(accel_x_mg_i) - DiffW'(last_x_q);
      entry_o.dy = DiffW'(accel_y_mg_i) - DiffW'(last_y_q);
      entry_o.dz = DiffW'(accel_z_mg_i) - DiffW'(last_z_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_last_q <= 1'b0;
    end else if (accept && read_ok_i) begin
      have_last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && read_ok_i) begin
      last_x_q <= accel_x_mg_i;
      last_y_q <= accel_y_mg_i;
      last_z_q <= accel_z_mg_i;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/vam_back.sv -----
`default_nettype none

module vam_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [13:0]          cfg_wdata_i,
  input  vam_pkg::q_stat_t    q_stat_i,
  input  vam_pkg::q_entry_t   entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [15:0]         vib_mag_o,
  output logic                vib_alarm_o,
  output logic                sample_valid_o,
  output logic                sensor_fault_o,
  output logic [15:0]         failure_count_o,
  output logic                recovered_o
);
  import vam_pkg::*;

  bk_state_e state_q, state_d;

  logic [LimitW-1:0]       limit_q;
  logic                    ok_q;
  logic signed [DiffW-1:0] dif_q [3];
  logic [1:0]              idx_q, idx_d;
  logic [SqW-1:0]          prod_q, prod_d;
  logic [SumW-1:0]         acc_q, acc_d, sum;
  logic [SumW-1:0]         n_q, n_d;
  logic [RemW-1:0]         rem_q, rem_d, rem_sh, trial;
  logic [MagW-1:0]         root_q, root_d;
  logic [StepW-1:0]        step_q, step_d;
  logic                    ge;
  logic signed [DiffW-1:0] op;
  logic [DiffW-1:0]        op_abs;

  // architectural state of the monitor
  logic [RunW-1:0]       run_q, run_d;
  logic [CountWidth-1:0] fail_q, fail_d;
  logic                  fault_q, fault_d;
  logic                  valid_q, valid_d;
  logic [MagW-1:0]       hmag_q, hmag_d;
  logic                  halarm_q, halarm_d;
  logic                  rec_d;

  logic out_free, commit, load;

  assign out_free = !out_valid_o || !out_stall_i;
  assign commit   = (state_q == BkCommit) && out_free;
  assign load     = (state_q == BkIdle) && !q_stat_i.empty;
  assign pop_o    = load;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: begin
        if (!q_stat_i.empty) begin
          state_d = entry_i.read_ok ? BkSquare : BkCommit;
        end
      end
      BkSquare: begin
        if (idx_q == 2'd3) state_d = BkRoot;
      end
      BkRoot: begin
        if (step_q == StepW'(RootSteps - 1)) state_d = BkCommit;
      end
      BkCommit: begin
        if (out_free) state_d = BkIdle;
      end
      default: state_d = BkIdle;
    endcase
  end

  // squares: one shared multiplier, product registered before the add
  always_comb begin
    case (idx_q)
      2'd0:    op = dif_q[0];
      2'd1:    op = dif_q[1];
      default: op = dif_q[2];
    endcase
    op_abs = op[DiffW-1] ? DiffW'(-op) : DiffW'(op);
    prod_d = SqW'(op_abs[AxisW-1:0]) * SqW'(op_abs[AxisW-1:0]);
    sum    = acc_q + SumW'(prod_q);
  end

  // one root bit per step
  always_comb begin
    rem_sh = {rem_q[RemW-3:0], n_q[SumW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // datapath and state updates
  always_comb begin
    idx_d  = idx_q;
    acc_d  = acc_q;
    n_d    = n_q;
    rem_d  = rem_q;
    root_d = root_q;
    step_d = step_q;
    case (state_q)
      BkIdle: begin
        idx_d  = 2'd0;
        acc_d  = '0;
        root_d = '0;
      end
      BkSquare: begin
        idx_d = idx_q + 2'd1;
        if (idx_q != 2'd0) acc_d = sum;
        if (idx_q == 2'd3) begin
          n_d    = sum;
          rem_d  = '0;
          root_d = '0;
          step_d = '0;
        end
      end
      BkRoot: begin
        n_d    = n_q << 2;
        rem_d  = ge ? rem_sh - trial : rem_sh;
        root_d = {root_q[MagW-2:0], ge};
        step_d = step_q + StepW'(1);
      end
      BkCommit: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    run_d    = run_q;
    fail_d   = fail_q;
    fault_d  = fault_q;
    valid_d  = valid_q;
    hmag_d   = hmag_q;
    halarm_d = halarm_q;
    rec_d    = 1'b0;
    if (ok_q) begin
      if (root_q >= MagW'(limit_q)) begin
        if (run_q < RunW'(AlarmRun)) run_d = run_q + RunW'(1);
      end else begin
        run_d = '0;
      end
      rec_d    = fault_q;
      hmag_d   = root_q;
      halarm_d = (run_d >= RunW'(AlarmRun));
      valid_d  = 1'b1;
      fail_d   = '0;
      fault_d  = 1'b0;
    end else begin
      if (fail_q != '1) fail_d = fail_q + CountWidth'(1);
      if (fail_d >= CountWidth'(FaultRun)) begin
        fault_d = 1'b1;
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      limit_q     <= LimitReset;
      out_valid_o <= 1'b0;
      run_q       <= '0;
      fail_q      <= '0;
      fault_q     <= 1'b0;
      valid_q     <= 1'b0;
      hmag_q      <= '0;
      halarm_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (commit) begin
        out_valid_o <= 1'b1;
        run_q       <= run_d;
        fail_q      <= fail_d;
        fault_q     <= fault_d;
        valid_q     <= valid_d;
        hmag_q      <= hmag_d;
        halarm_q    <= halarm_d;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    step_q <= step_d;
    if (load) begin
      ok_q     <= entry_i.read_ok;
      dif_q[0] <= entry_i.dx;
      dif_q[1] <= entry_i.dy;
      dif_q[2] <= entry_i.dz;
    end
    if (commit) begin
      vib_mag_o       <= hmag_d;
      vib_alarm_o     <= halarm_d;
      sample_valid_o  <= valid_d;
      sensor_fault_o  <= fault_d;
      failure_count_o <= FcntW'(fail_d);
      recovered_o     <= rec_d;
    end
  end

endmodule

`default_nettype wire
